FILE: rtl/mexp_pkg.sv
// Package with shared constants for the modular exponentiation unit.
package mexp_pkg;
	localparam int MODULUS_BITS_DEF = 31;
	localparam int OPERAND_BITS = 64;
endpackage

FILE: rtl/modular_exponentiation_unit.sv
// Every modular reduction runs on the shared bit-serial divider.
// A positive exponent of k bits costs up to 2k+1 reductions.
// A negative exponent adds extended Euclid steps, one division each (up to ~46 steps).
// One item at a time: in_ready is low from acceptance until the result beat is taken.
// A configuration beat wins over an operand beat offered in the same idle cycle.
// Reset is asynchronous, active low; the modulus register resets to 1.
module modular_exponentiation_unit
	import mexp_pkg::*;
#(
	parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [30:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [63:0]        base,
	input  logic signed [63:0]        exponent,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [30:0]               result,
	output logic                      no_inverse
);
	localparam int MB = MODULUS_BITS;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RBASE = 9'b000000010,
		ST_BIT   = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_SQ    = 9'b000010000,
		ST_EUC   = 9'b000100000,
		ST_EUCW  = 9'b001000000,
		ST_FIX   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [MB-1:0]        mod_q;
	logic [MB-1:0]        m_eff;
	logic [63:0]          exp_q;
	logic                 neg_q;
	logic                 bneg_q;
	logic [MB-1:0]        acc_q;
	logic [MB-1:0]        sq_q;
	logic [MB-1:0]        ex_q;
	logic [MB-1:0]        ey_q;
	logic signed [MB+1:0] cu_q;
	logic signed [MB+1:0] cv_q;
	logic [30:0]          res_q;
	logic                 noinv_q;
	logic                 dv_start;
	logic [63:0]          dv_a;
	logic [MB-1:0]        dv_b;
	logic                 dv_done;
	logic [63:0]          dv_quo;
	logic [MB-1:0]        dv_rem;
	logic [MB-1:0]        mul_a;
	logic [2*MB-1:0]      mul_p;
	logic [63:0]          bmag;
	logic signed [MB+1:0] nu;
	logic [MB-1:0]        cu_abs_rem;

	assign m_eff = (mod_q == '0) ? MB'(1) : mod_q;

	mexp_divider #(.MB(MB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .done(dv_done), .quotient(dv_quo), .remainder(dv_rem)
	);

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid = (state_q == ST_OUT);
	assign result    = res_q;
	assign no_inverse = noinv_q;

	assign bmag = base[63] ? (~base + 64'd1) : base;
	// One shared residue multiplier: acc times square on a set bit, else square times square.
	assign mul_a = (state_q == ST_BIT && exp_q[0]) ? acc_q : sq_q;
	assign mul_p = mul_a * sq_q;
	// Euclid cofactor update uses the narrow quotient of two residues.
	assign nu = cu_q - signed'(dv_quo[MB+1:0]) * cv_q;
	assign cu_abs_rem = dv_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mod_q    <= MB'(1);
			dv_start <= 1'b0;
		end else begin
			dv_start <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) mod_q <= cfg_data[MB-1:0];
					if (in_valid && in_ready) begin
						exp_q  <= exponent[63] ? (~exponent + 64'd1) : exponent;
						neg_q  <= exponent[63];
						bneg_q <= base[63];
						acc_q  <= MB'(1);
						if (exponent == 64'sd0) begin
							res_q   <= 31'd1;
							noinv_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							dv_a     <= bmag;
							dv_b     <= m_eff;
							dv_start <= 1'b1;
							state_q  <= ST_RBASE;
						end
					end
				end
				ST_RBASE: if (dv_done) begin
					sq_q    <= (bneg_q && dv_rem != '0) ? m_eff - dv_rem : dv_rem;
					state_q <= ST_BIT;
				end
				// Scan exponent bits from the least significant end.
				ST_BIT: begin
					if (exp_q == 64'd0) begin
						if (neg_q) begin
							ex_q <= acc_q; ey_q <= m_eff;
							cu_q <= (MB+2)'(1); cv_q <= '0;
							state_q <= ST_EUC;
						end else begin
							res_q   <= 31'(acc_q);
							noinv_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end else if (exp_q[0]) begin
						dv_a     <= 64'(mul_p);
						dv_b     <= m_eff;
						dv_start <= 1'b1;
						state_q  <= ST_MUL;
					end else begin
						dv_a     <= 64'(mul_p);
						dv_b     <= m_eff;
						dv_start <= 1'b1;
						state_q  <= ST_SQ;
					end
				end
				ST_MUL: if (dv_done) begin
					acc_q    <= dv_rem;
					dv_a     <= 64'(mul_p);
					dv_start <= 1'b1;
					state_q  <= ST_SQ;
				end
				ST_SQ: if (dv_done) begin
					sq_q    <= dv_rem;
					exp_q   <= exp_q >> 1;
					state_q <= ST_BIT;
				end
				// Extended Euclid, one division per step.
				ST_EUC: begin
					if (ey_q == '0) begin
						noinv_q <= (ex_q != MB'(1));
						dv_a    <= cu_q[MB+1] ? 64'(-cu_q) : 64'(cu_q);
						dv_b    <= m_eff;
						dv_start <= 1'b1;
						state_q <= ST_FIX;
					end else begin
						dv_a     <= 64'(ex_q);
						dv_b     <= ey_q;
						dv_start <= 1'b1;
						state_q  <= ST_EUCW;
					end
				end
				ST_EUCW: if (dv_done) begin
					ex_q <= ey_q;
					ey_q <= dv_rem;
					cu_q <= cv_q;
					cv_q <= nu;
					state_q <= ST_EUC;
				end
				ST_FIX: if (dv_done) begin
					res_q <= 31'((cu_q[MB+1] && cu_abs_rem != '0) ?
						m_eff - cu_abs_rem : cu_abs_rem);
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/mexp_divider.sv
// Restoring divider: one quotient bit per cycle, 64-bit dividend, narrow divisor.
module mexp_divider
	import mexp_pkg::*;
#(
	parameter int MB = MODULUS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] dividend,
	input  logic [MB-1:0]           divisor,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] quotient,
	output logic [MB-1:0]           remainder
);
	localparam int CW = $clog2(OPERAND_BITS + 1);

	logic [OPERAND_BITS-1:0] quo_q;
	logic [MB:0]             rem_q;
	logic [MB-1:0]           div_q;
	logic [CW-1:0]           cnt_q;
	logic                    busy_q;
	logic [MB:0]             trial;
	logic [MB:0]             diff;

	// One shift-subtract step.
	assign trial = {rem_q[MB-1:0], quo_q[OPERAND_BITS-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(OPERAND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[MB]) begin
				rem_q <= diff;
				quo_q <= {quo_q[OPERAND_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[OPERAND_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[MB-1:0];
endmodule

FILE: rtl/mexp_checker.sv
// Port-level checker for the modular exponentiation unit, with its bind.
module mexp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] result,
	input logic        no_inverse
);
	// The block never takes input while a result beat is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("ready while result pending");
	// A taken input beat drops in_ready in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result) &&
		$stable(no_inverse))) else $error("result changed while stalled");
endmodule

bind modular_exponentiation_unit mexp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result(result),
	.no_inverse(no_inverse)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the modular exponentiation unit with a built-in predictor.
module tb;
	import mexp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD = 8;
	localparam int MAX_GAP = 18;

	// One directed row: modulus to run under, operands, and an optional typed answer.
	typedef struct {
		logic [30:0] modv;
		logic [63:0] b;
		logic [63:0] e;
		bit          typed;
		logic [30:0] r;
		bit          ni;
	} row_t;

	typedef struct {
		logic [30:0] r;
		logic        ni;
	} power_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [30:0]         cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic signed [63:0]  base = '0;
	logic signed [63:0]  exponent = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [30:0]         result;
	logic                no_inverse;

	power_t      pending_powers[$];
	logic [30:0] modulus_shadow = 31'd1;
	bit          quiet = 1'b0;
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          inverse_fails = 0;
	row_t        rows[$];

	modular_exponentiation_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.base      (base),
		.exponent  (exponent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.no_inverse(no_inverse)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Computes base^exponent mod the modulus register, inverting for negative exponents.
	function automatic power_t modpow(input logic [63:0] b_in, input logic [63:0] e_in,
			input logic [30:0] mreg);
		longint unsigned m, b, e, acc, sq, mag;
		longint x, y, cu, cv, q, nx, nu, sm;
		power_t p;
		m = (mreg == 0) ? 64'd1 : {33'd0, mreg};
		p.ni = 1'b0;
		if (e_in == 0) begin
			p.r = 31'd1;
			return p;
		end
		// Bring the signed base into [0, m).
		if (!b_in[63]) begin
			b = b_in % m;
		end else begin
			mag = ~b_in + 64'd1;
			b = mag % m;
			if (b != 0) b = m - b;
		end
		e = e_in[63] ? (~e_in + 64'd1) : e_in;
		acc = 1;
		sq = b;
		while (e != 0) begin
			if (e[0]) acc = (acc * sq) % m;
			sq = (sq * sq) % m;
			e = e >> 1;
		end
		if (!e_in[63]) begin
			p.r = acc[30:0];
			return p;
		end
		// Extended Euclid; the final coefficient is the inverse when the gcd is one.
		x = acc;
		y = m;
		cu = 1;
		cv = 0;
		while (y > 0) begin
			q = x / y;
			nx = x - q * y;
			nu = cu - q * cv;
			x = y;
			y = nx;
			cu = cv;
			cv = nu;
		end
		p.ni = (x != 1);
		sm = m;
		if (cu >= 0) acc = cu % sm;
		else acc = (sm - ((-cu) % sm)) % sm;
		p.r = acc[30:0];
		return p;
	endfunction

	// Drop the operand valid and wait until every expected result beat has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_powers.size() != 0) @(posedge clk);
	endtask

	// Write the modulus register while the unit is idle.
	task automatic write_modulus(input logic [30:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		modulus_shadow = v;
	endtask

	// Send one operand beat; the expectation is queued at acceptance.
	// Valid stays up after acceptance only until the next call or a drain in the same step.
	task automatic send_operands(input logic [63:0] b, input logic [63:0] e, input bit typed,
			input logic [30:0] r, input bit ni);
		int gap;
		power_t p;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (!(in_valid && in_ready));
		p = modpow(b, e, modulus_shadow);
		if (typed) begin
			p.r = r;
			p.ni = ni;
		end
		pending_powers.push_back(p);
		items_sent++;
	endtask

	// Result side: stall a random number of cycles before each beat, except in the quiet phase.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		power_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (out_valid && no_inverse) inverse_fails++;
			if (pending_powers.size() == 0) begin
				$display("%0t unexpected result beat: result %0d no_inverse %0b",
					$time, result, no_inverse);
				errors++;
			end else begin
				want = pending_powers.pop_front();
				if (result !== want.r) begin
					$display("%0t result mismatch: expected %0d actual %0d",
						$time, want.r, result);
					errors++;
				end
				if (no_inverse !== want.ni) begin
					$display("%0t no_inverse mismatch: expected %0b actual %0b",
						$time, want.ni, no_inverse);
					errors++;
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	initial begin
		#(100_000_000);
		$display("%0t timeout with %0d results outstanding", $time, pending_powers.size());
		$display("== FAIL ==");
		$finish;
	end

	// Build the directed table: special cases and extremes first.
	function automatic row_t mk(input logic [30:0] modv, input logic [63:0] b,
			input logic [63:0] e, input bit typed, input logic [30:0] r, input bit ni);
		row_t x;
		x.modv = modv;
		x.b = b;
		x.e = e;
		x.typed = typed;
		x.r = r;
		x.ni = ni;
		return x;
	endfunction

	// Draw a base that hits small values, multiples of the modulus, extremes and plain random words.
	function automatic logic [63:0] pick_base(input logic [30:0] modv);
		logic [63:0] v;
		case ($urandom_range(0, 4))
			0: v = {$urandom, $urandom};
			1: v = 64'($signed($urandom_range(0, 80)) - 40);
			2: v = 64'(modv) * $urandom_range(0, 5);
			3: v = $urandom_range(0, 1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	// Draw an exponent: mostly short magnitudes, a few full width, zero and the most negative value, both signs.
	function automatic logic [63:0] pick_exponent();
		logic [63:0] mag;
		int nbits;
		if ($urandom_range(0, 40) == 0) return {1'b1, 63'd0};
		if ($urandom_range(0, 12) == 0) return 64'd0;
		nbits = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 12);
		mag = {$urandom, $urandom} & ((64'd1 << nbits) - 64'd1);
		return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
	endfunction

	initial begin
		logic [30:0] moduli[$];
		logic [30:0] modv;
		localparam logic [63:0] MIN64 = {1'b1, 63'd0};
		localparam logic [63:0] MAX64 = {1'b0, {63{1'b1}}};
		localparam logic [30:0] MERSENNE = 31'h7FFF_FFFF;

		// Modulus one from reset, then the zero register that acts as one.
		rows.push_back(mk(31'd1, 64'd5, 64'd0, 1, 31'd1, 0));
		rows.push_back(mk(31'd1, 64'd5, 64'd3, 1, 31'd0, 0));
		rows.push_back(mk(31'd1, -64'd1, -64'd1, 1, 31'd0, 0));
		rows.push_back(mk(31'd0, 64'd7, 64'd5, 1, 31'd0, 0));
		rows.push_back(mk(31'd0, 64'd7, 64'd0, 1, 31'd1, 0));
		// Composite modulus: missing inverses, a zero power, signed extremes.
		rows.push_back(mk(31'd12, 64'd2, -64'd1, 0, 31'd0, 0));
		rows.push_back(mk(31'd12, 64'd0, -64'd3, 1, 31'd0, 1));
		rows.push_back(mk(31'd12, 64'd5, -64'd1, 0, 31'd0, 0));
		rows.push_back(mk(31'd12, -64'd7, 64'd2, 0, 31'd0, 0));
		rows.push_back(mk(31'd12, MIN64, 64'd1, 0, 31'd0, 0));
		rows.push_back(mk(31'd12, MAX64, MAX64, 0, 31'd0, 0));
		rows.push_back(mk(31'd12, 64'd3, MIN64, 0, 31'd0, 0));
		// Largest prime modulus.
		rows.push_back(mk(MERSENNE, 64'd2, 64'd30, 1, 31'd1073741824, 0));
		rows.push_back(mk(MERSENNE, -64'd1, 64'd2, 1, 31'd1, 0));
		rows.push_back(mk(MERSENNE, MAX64, -64'd1, 0, 31'd0, 0));
		rows.push_back(mk(MERSENNE, MIN64, MIN64, 0, 31'd0, 0));
		rows.push_back(mk(MERSENNE, 64'd0, 64'd0, 1, 31'd1, 0));
		rows.push_back(mk(MERSENNE, 64'd2147483646, 64'd2, 1, 31'd1, 0));
		rows.push_back(mk(MERSENNE, 64'd2147483647, 64'd5, 1, 31'd0, 0));
		// Smallest real modulus and the largest even one.
		rows.push_back(mk(31'd2, 64'd3, -64'd5, 0, 31'd0, 0));
		rows.push_back(mk(31'd2147483646, 64'd3, -64'd2, 0, 31'd0, 0));
		rows.push_back(mk(31'd2147483646, 64'd2147483645, 64'd1, 0, 31'd0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (rows[i]) begin
			if (rows[i].modv != modulus_shadow || i == 3) write_modulus(rows[i].modv);
			send_operands(rows[i].b, rows[i].e, rows[i].typed, rows[i].r, rows[i].ni);
		end

		// Random phases, each under its own modulus; one phase runs with no idling.
		moduli = '{31'd7, 31'd12, 31'd1, MERSENNE, 31'd0, 31'd2147483646, 31'd2,
			31'($urandom_range(3, 65535)), 31'($urandom_range(2, 32'h7FFF_FFFF))};
		foreach (moduli[ph]) begin
			write_modulus(moduli[ph]);
			quiet = (ph == 3);
			modv = (moduli[ph] == 0) ? 31'd1 : moduli[ph];
			repeat (13) send_operands(pick_base(modv), pick_exponent(), 0, 31'd0, 0);
			// Hold the sender until the unit has handed back everything.
			if (ph == 5) drain();
		end
		quiet = 1'b0;

		drain();
		repeat (200) @(posedge clk);
		if (pending_powers.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, pending_powers.size());
			errors++;
		end
		$display("Sent %0d operand beats over %0d moduli;", items_sent, moduli.size() + 6);
		$display("%0d results checked, %0d without inverse.", results_seen, inverse_fails);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/mexp_pkg.sv
rtl/mexp_divider.sv
rtl/modular_exponentiation_unit.sv
rtl/mexp_checker.sv
tb/sv/tb.sv
